// File: sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants of the proximity speed governor
// Widths, register indexes, drive actions and the structures passed between
// the lane, merge and ramp logic.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Sensor count (front pairs plus the rear pair) and internal distance width.
  localparam int SENSORS   = 6;
  localparam int DIST_BITS = 10;

  // Fixed widths of the port fields and configuration registers.
  localparam int FIELD_W    = 10;
  localparam int CFG_DIST_W = 10;
  localparam int SCALE_W    = 4;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Number of front sensor pairs on the ports, and how many are examined.
  localparam int FRONT_PORTS = 5;
  localparam int FRONT_LANES = (SENSORS - 1 > FRONT_PORTS) ? FRONT_PORTS : SENSORS - 1;

  // Derived widths: field extension, comparison width and target width.
  localparam int EXT_W = (FIELD_W > DIST_BITS) ? FIELD_W : DIST_BITS;
  localparam int CMP_W = (DIST_BITS > CFG_DIST_W) ? DIST_BITS : CFG_DIST_W;
  localparam int TGT_W = CMP_W + SCALE_W + 2;

  // Value of the nearest distance when nothing is near.
  localparam logic [DIST_BITS-1:0] NEAR_NONE = DIST_BITS'(255);

  // Reset values.
  localparam logic [LIMIT_W-1:0]    FULL_RESET      = LIMIT_W'(100);
  localparam logic [CFG_DIST_W-1:0] SLOW_RESET      = CFG_DIST_W'(70);
  localparam logic [CFG_DIST_W-1:0] IR_SLOW_RESET   = CFG_DIST_W'(60);
  localparam logic [CFG_DIST_W-1:0] HALT_RESET      = CFG_DIST_W'(10);
  localparam logic [SCALE_W-1:0]    SCALE_RESET     = SCALE_W'(1);
  localparam logic [LIMIT_W-1:0]    MIN_LIMIT_RESET = LIMIT_W'(5);
  localparam logic [LIMIT_W-1:0]    MAX_LIMIT_RESET = LIMIT_W'(100);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW      = 3'd0,
    CFG_IR_SLOW   = 3'd1,
    CFG_HALT      = 3'd2,
    CFG_SCALE     = 3'd3,
    CFG_MIN_LIMIT = 3'd4,
    CFG_MAX_LIMIT = 3'd5
  } cfg_idx_t;

  // Drive override commands.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_STOP = 2'd1,
    ACT_BACK = 2'd2
  } action_t;

  typedef logic [DIST_BITS-1:0] dist_t;

  // Configuration register set.
  typedef struct packed {
    logic [CFG_DIST_W-1:0] slow;
    logic [CFG_DIST_W-1:0] ir_slow;
    logic [CFG_DIST_W-1:0] halt;
    logic [SCALE_W-1:0]    scale;
    logic [LIMIT_W-1:0]    min_lim;
    logic [LIMIT_W-1:0]    max_lim;
  } cfg_t;

  // What one front lane found.
  typedef struct packed {
    dist_t near;
    logic  blocked;
  } lane_res_t;

  // Merged result of one scan.
  typedef struct packed {
    dist_t near_front;
    dist_t near_rear;
    logic  blocked;
    logic  recede;
  } scan_t;

  // Brings a port field to the internal distance width.
  function automatic dist_t dist_of(input logic [FIELD_W-1:0] v);
    logic [EXT_W-1:0] t;
    t = EXT_W'(v);
    return t[DIST_BITS-1:0];
  endfunction

  // Unsigned compare of a distance against a threshold register.
  function automatic logic below(input dist_t d, input logic [CFG_DIST_W-1:0] thr);
    return CMP_W'(d) < CMP_W'(thr);
  endfunction

endpackage

// File: sv/psg_lane.sv
// ----------------------------------------------------------------------------
// psg_lane: one front sensor pair
// Qualifies the ultrasonic and infrared readings against their slow-down
// thresholds, keeps the nearer one and flags a reading below halt distance.
// ----------------------------------------------------------------------------
module psg_lane (
  input  logic [psg_pkg::FIELD_W-1:0] ping,
  input  logic [psg_pkg::FIELD_W-1:0] ir,
  input  psg_pkg::cfg_t               cfg,
  output psg_pkg::lane_res_t          res
);

  psg_pkg::dist_t d_ping;
  psg_pkg::dist_t d_ir;
  psg_pkg::dist_t c_ping;
  psg_pkg::dist_t c_ir;
  logic           near_ping;
  logic           near_ir;

  // A reading that is not near stands in as the nothing-near value.
  always_comb begin
    d_ping    = psg_pkg::dist_of(ping);
    d_ir      = psg_pkg::dist_of(ir);
    near_ping = psg_pkg::below(d_ping, cfg.slow);
    near_ir   = psg_pkg::below(d_ir, cfg.ir_slow);
    c_ping    = near_ping ? d_ping : psg_pkg::NEAR_NONE;
    c_ir      = near_ir ? d_ir : psg_pkg::NEAR_NONE;
    res.near  = (c_ir < c_ping) ? c_ir : c_ping;
    res.blocked = (near_ping && psg_pkg::below(d_ping, cfg.halt)) ||
                  (near_ir && psg_pkg::below(d_ir, cfg.halt));
  end

endmodule

// File: sv/psg_merge.sv
// ----------------------------------------------------------------------------
// psg_merge: combines the front lanes and evaluates the rear pair
// Takes the minimum over the lanes, ORs their blocked flags and works out
// the rear nearest distance and whether reversing is safe.
// ----------------------------------------------------------------------------
module psg_merge (
  input  psg_pkg::lane_res_t          lanes [psg_pkg::FRONT_LANES],
  input  logic [psg_pkg::FIELD_W-1:0] rear_ping,
  input  logic [psg_pkg::FIELD_W-1:0] rear_ir,
  input  psg_pkg::cfg_t               cfg,
  output psg_pkg::scan_t              scan
);

  psg_pkg::dist_t min_v;
  logic           blk;
  psg_pkg::dist_t rp;
  psg_pkg::dist_t ri;
  psg_pkg::dist_t rear_v;

  // Minimum and blocked flag across the front lanes.
  always_comb begin
    min_v = psg_pkg::NEAR_NONE;
    blk   = 1'b0;
    for (int i = 0; i < psg_pkg::FRONT_LANES; i++) begin
      if (lanes[i].near < min_v) begin
        min_v = lanes[i].near;
      end
      blk = blk | lanes[i].blocked;
    end
  end

  // Rear pair: the ultrasonic reading replaces the default when below its slow
  // threshold, the infrared one only where it is below its own and nearer still.
  always_comb begin
    rp     = psg_pkg::dist_of(rear_ping);
    ri     = psg_pkg::dist_of(rear_ir);
    rear_v = psg_pkg::below(rp, cfg.slow) ? rp : psg_pkg::NEAR_NONE;
    if (psg_pkg::below(ri, cfg.ir_slow) && (ri < rear_v)) begin
      rear_v = ri;
    end
  end

  always_comb begin
    scan.near_front = min_v;
    scan.near_rear  = rear_v;
    scan.blocked    = blk;
    scan.recede     = !(psg_pkg::below(rp, cfg.halt) || psg_pkg::below(ri, cfg.halt));
  end

endmodule

// File: sv/psg_ramp.sv
// ----------------------------------------------------------------------------
// psg_ramp: one speed limit ramp step
// Computes the clamped target from the nearest distance and moves the limit
// one step towards it, or jumps to the full limit when nothing is near.
// ----------------------------------------------------------------------------
module psg_ramp (
  input  logic [psg_pkg::LIMIT_W-1:0] cur,
  input  psg_pkg::dist_t              near,
  input  psg_pkg::cfg_t               cfg,
  output logic [psg_pkg::LIMIT_W-1:0] nxt
);

  logic signed [psg_pkg::CMP_W:0]   diff;
  logic signed [psg_pkg::TGT_W-1:0] diff_ext;
  logic signed [psg_pkg::TGT_W-1:0] scale_ext;
  logic signed [psg_pkg::TGT_W-1:0] prod;
  logic signed [psg_pkg::TGT_W-1:0] min_ext;
  logic signed [psg_pkg::TGT_W-1:0] max_ext;
  logic [psg_pkg::LIMIT_W-1:0]      target;

  // Excess distance over the halt distance, scaled.
  always_comb begin
    diff      = $signed({1'b0, psg_pkg::CMP_W'(near)}) -
                $signed({1'b0, psg_pkg::CMP_W'(cfg.halt)});
    diff_ext  = psg_pkg::TGT_W'(diff);
    scale_ext = $signed(psg_pkg::TGT_W'(cfg.scale));
    prod      = diff_ext * scale_ext;
  end

  // Clamp: the lower bound is tested first, so a product below it takes it.
  always_comb begin
    min_ext = $signed(psg_pkg::TGT_W'(cfg.min_lim));
    max_ext = $signed(psg_pkg::TGT_W'(cfg.max_lim));
    if (prod < min_ext) begin
      target = cfg.min_lim;
    end else if (prod > max_ext) begin
      target = cfg.max_lim;
    end else begin
      target = prod[psg_pkg::LIMIT_W-1:0];
    end
  end

  // One step towards the target.
  always_comb begin
    if (!psg_pkg::below(near, cfg.slow)) begin
      nxt = cfg.max_lim;
    end else if (target > cur) begin
      nxt = cur + psg_pkg::LIMIT_W'(1);
    end else if (target < cur) begin
      nxt = cur - psg_pkg::LIMIT_W'(1);
    end else begin
      nxt = cur;
    end
  end

endmodule

// File: sv/proximity_speed_governor_top.sv
// ----------------------------------------------------------------------------
// proximity_speed_governor_top: obstacle-aware speed limiter
// Evaluates one distance scan per word and produces the ramped speed limits,
// safety flags and drive override command.
// ----------------------------------------------------------------------------
// Use: each input word is one full scan (five front ultrasonic/infrared pairs
// and the rear pair). A word is taken when in_valid is high and in_stall is
// low; each word yields exactly one output word, presented on out_valid and
// held while out_stall is high.
// Once a word is accepted, the front lanes and the merge stage fill a scan
// register; then the ramp and escape logic update the state and load the
// output register, which raises out_valid. One word per cycle is sustained
// while the receiver does not stall; the scan register and the output
// register each hold a word, so in_stall rises only once both are full and
// the receiver stalls.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; registers should be written only while no scan is in flight.
// An index beyond the register list is ignored.
// Reset (rst_n low, synchronous) empties the pipeline, restores the default
// thresholds, sets both limits to full speed and clears the escape flag.
// ----------------------------------------------------------------------------
module proximity_speed_governor_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Scan input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ping_0,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ping_1,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ping_2,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ping_3,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ping_4,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ir_0,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ir_1,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ir_2,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ir_3,
  input  logic [psg_pkg::FIELD_W-1:0]            in_front_ir_4,
  input  logic [psg_pkg::FIELD_W-1:0]            in_rear_ping,
  input  logic [psg_pkg::FIELD_W-1:0]            in_rear_ir,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_safe_to_proceed,
  output logic                                   out_safe_to_recede,
  output logic                                   out_escaping,
  output logic [psg_pkg::LIMIT_W-1:0]            out_forward_limit,
  output logic [psg_pkg::LIMIT_W-1:0]            out_reverse_limit,
  output logic [1:0]                             out_drive_action,
  // Configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [psg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // Configuration registers.
  psg_pkg::cfg_t cfg_r;

  // Pipeline control.
  logic a_valid_r;
  logic a_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;
  logic a_adv;
  logic in_acc;

  // Scan register and state.
  psg_pkg::scan_t  scan_r;
  psg_pkg::scan_t  scan_nxt;
  logic [psg_pkg::LIMIT_W-1:0] fwd_r;
  logic [psg_pkg::LIMIT_W-1:0] fwd_nxt;
  logic [psg_pkg::LIMIT_W-1:0] rev_r;
  logic [psg_pkg::LIMIT_W-1:0] rev_nxt;
  logic                        esc_r;
  logic                        esc_nxt;
  psg_pkg::action_t            act_nxt;

  // Output payload registers.
  logic                        proceed_r;
  logic                        recede_r;
  logic                        escaping_r;
  logic [psg_pkg::LIMIT_W-1:0] fwd_out_r;
  logic [psg_pkg::LIMIT_W-1:0] rev_out_r;
  psg_pkg::action_t            act_r;

  // Front lane inputs gathered into arrays.
  logic [psg_pkg::FIELD_W-1:0] front_ping [psg_pkg::FRONT_PORTS];
  logic [psg_pkg::FIELD_W-1:0] front_ir   [psg_pkg::FRONT_PORTS];
  psg_pkg::lane_res_t          lane_res   [psg_pkg::FRONT_LANES];

  assign front_ping[0] = in_front_ping_0;
  assign front_ping[1] = in_front_ping_1;
  assign front_ping[2] = in_front_ping_2;
  assign front_ping[3] = in_front_ping_3;
  assign front_ping[4] = in_front_ping_4;
  assign front_ir[0]   = in_front_ir_0;
  assign front_ir[1]   = in_front_ir_1;
  assign front_ir[2]   = in_front_ir_2;
  assign front_ir[3]   = in_front_ir_3;
  assign front_ir[4]   = in_front_ir_4;

  // Configuration port: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow    <= psg_pkg::SLOW_RESET;
      cfg_r.ir_slow <= psg_pkg::IR_SLOW_RESET;
      cfg_r.halt    <= psg_pkg::HALT_RESET;
      cfg_r.scale   <= psg_pkg::SCALE_RESET;
      cfg_r.min_lim <= psg_pkg::MIN_LIMIT_RESET;
      cfg_r.max_lim <= psg_pkg::MAX_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (psg_pkg::cfg_idx_t'(cfg_index))
        psg_pkg::CFG_SLOW:      cfg_r.slow    <= cfg_data[psg_pkg::CFG_DIST_W-1:0];
        psg_pkg::CFG_IR_SLOW:   cfg_r.ir_slow <= cfg_data[psg_pkg::CFG_DIST_W-1:0];
        psg_pkg::CFG_HALT:      cfg_r.halt    <= cfg_data[psg_pkg::CFG_DIST_W-1:0];
        psg_pkg::CFG_SCALE:     cfg_r.scale   <= cfg_data[psg_pkg::SCALE_W-1:0];
        psg_pkg::CFG_MIN_LIMIT: cfg_r.min_lim <= cfg_data[psg_pkg::LIMIT_W-1:0];
        psg_pkg::CFG_MAX_LIMIT: cfg_r.max_lim <= cfg_data[psg_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front lanes, one per examined sensor pair.
  for (genvar g = 0; g < psg_pkg::FRONT_LANES; g++) begin : g_lane
    psg_lane u_lane (
      .ping (front_ping[g]),
      .ir   (front_ir[g]),
      .cfg  (cfg_r),
      .res  (lane_res[g])
    );
  end

  // Merge of the lanes with the rear pair.
  psg_merge u_merge (
    .lanes     (lane_res),
    .rear_ping (in_rear_ping),
    .rear_ir   (in_rear_ir),
    .cfg       (cfg_r),
    .scan      (scan_nxt)
  );

  // Ramp units for the forward and reverse limits.
  psg_ramp u_ramp_fwd (
    .cur  (fwd_r),
    .near (scan_r.near_front),
    .cfg  (cfg_r),
    .nxt  (fwd_nxt)
  );

  psg_ramp u_ramp_rev (
    .cur  (rev_r),
    .near (scan_r.near_rear),
    .cfg  (cfg_r),
    .nxt  (rev_nxt)
  );

  // Escape flag and override command.
  always_comb begin
    if (!scan_r.blocked) begin
      esc_nxt = 1'b0;
      act_nxt = esc_r ? psg_pkg::ACT_STOP : psg_pkg::ACT_NONE;
    end else begin
      esc_nxt = 1'b1;
      act_nxt = scan_r.recede ? psg_pkg::ACT_BACK : psg_pkg::ACT_STOP;
    end
  end

  // Handshake: the output register frees when empty or taken this cycle.
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    a_adv         = a_valid_r && out_free;
    in_stall      = a_valid_r && !out_free;
    in_acc        = in_valid && !in_stall;
    a_valid_nxt   = in_acc ? 1'b1 : (a_adv ? 1'b0 : a_valid_r);
    out_valid_nxt = a_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= psg_pkg::FULL_RESET;
      rev_r       <= psg_pkg::FULL_RESET;
      esc_r       <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_adv) begin
        fwd_r <= fwd_nxt;
        rev_r <= rev_nxt;
        esc_r <= esc_nxt;
      end
    end
  end

  // Payload registers of the scan and output stages.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      scan_r <= scan_nxt;
    end
    if (a_adv) begin
      proceed_r  <= !scan_r.blocked;
      recede_r   <= scan_r.recede;
      escaping_r <= esc_nxt;
      fwd_out_r  <= fwd_nxt;
      rev_out_r  <= rev_nxt;
      act_r      <= act_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_safe_to_proceed = proceed_r;
  assign out_safe_to_recede  = recede_r;
  assign out_escaping        = escaping_r;
  assign out_forward_limit   = fwd_out_r;
  assign out_reverse_limit   = rev_out_r;
  assign out_drive_action    = act_r;

  // The escape flag shown always mirrors the blocked condition of that word.
  a_esc_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_escaping == !out_safe_to_proceed))
    else $error("escaping flag disagrees with blocked front");

  // Backing off is only commanded while escaping with a clear rear.
  a_back_off : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive_action == psg_pkg::ACT_BACK)) |->
      (out_safe_to_recede && out_escaping))
    else $error("back-off command without a clear rear");

  // The presented limits are the current ramp state.
  a_limit_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_forward_limit == fwd_r) && (out_reverse_limit == rev_r)))
    else $error("output limits differ from ramp state");

endmodule
